[design/dhdo_pkg.sv]
`default_nettype none

package dhdo_pkg;

    localparam int DEN_W  = 36;
    localparam int RATE_W = 21;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_PWM_PERIOD   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LINK_TIMEOUT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DEFAULT_IVL  = 2'd2;

    localparam logic [CFG_W-1:0] RST_PWM_PERIOD   = 16'd499;
    localparam logic [CFG_W-1:0] RST_LINK_TIMEOUT = 16'd500;
    localparam logic [CFG_W-1:0] RST_DEFAULT_IVL  = 16'd100;

    localparam logic OP_CMD    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [7:0] DIR_FWD = 8'd1;

    // bit 0 = pin a, bit 1 = pin b
    localparam logic [1:0] PINS_STOP = 2'b00;
    localparam logic [1:0] PINS_FWD  = 2'b10;
    localparam logic [1:0] PINS_REV  = 2'b01;

    localparam logic [DEN_W-1:0]  CMP_DIVISOR = 36'd255;
    localparam logic [9:0]        RATE_SCALE  = 10'd550;
    localparam logic [RATE_W-1:0] RATE_MAX    = 21'h1FFFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [1:0] pins_for(input logic [7:0] speed, input logic [7:0] dir);
        logic [1:0] pins;
        if (speed == 8'd0) begin
            pins = PINS_STOP;
        end else if (dir == DIR_FWD) begin
            pins = PINS_FWD;
        end else begin
            pins = PINS_REV;
        end
        return pins;
    endfunction

endpackage

`default_nettype wire

[design/dhdo_div.sv]
`default_nettype none

module dhdo_div import dhdo_pkg::*; #(
    parameter int NUM_W = 26
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output t_div_stat             o_stat,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_count;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W+1:0] w_diff;
    logic             w_ge;

    // restoring division, one quotient bit per cycle shifted into r_num
    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
        w_ge    = !w_diff[DEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

`default_nettype wire

[design/dual_hbridge_drive_with_odometry_unit.sv]
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------
// input    | i_in_valid / o_in_ready   | opcode, now_ms, speed/dir cmds, counters
// output   | o_out_valid / i_out_ready | bridge pins, compares, rates, feedback
// config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data (always ready)
//
// One item at a time: a new item is taken only in S_IDLE, once the last result is
// loaded. NUM_W is max(COUNTER_BITS + 10, 24): the bit-serial restoring dividers
// return one quotient bit per cycle, both motors in parallel.
// Synchronous active-low reset restores the register defaults and zeroes control and odometry state.
// A result not yet taken holds the next item in its final state.

module dual_hbridge_drive_with_odometry_unit import dhdo_pkg::*; #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,

    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_opcode,
    input  wire logic [31:0]       i_now_ms,
    input  wire logic [7:0]        i_left_speed_cmd,
    input  wire logic [7:0]        i_left_dir_cmd,
    input  wire logic [7:0]        i_right_speed_cmd,
    input  wire logic [7:0]        i_right_dir_cmd,
    input  wire logic [15:0]       i_left_counter,
    input  wire logic [15:0]       i_right_counter,

    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_left_pin_a,
    output logic                   o_left_pin_b,
    output logic                   o_right_pin_a,
    output logic                   o_right_pin_b,
    output logic [15:0]            o_left_compare,
    output logic [15:0]            o_right_compare,
    output logic [RATE_W-1:0]      o_left_rate,
    output logic [RATE_W-1:0]      o_right_rate,
    output logic [15:0]            o_left_feedback,
    output logic [15:0]            o_right_feedback
);

    localparam int CB    = COUNTER_BITS;
    localparam int NUM_W = (CB + 10 > 24) ? CB + 10 : 24;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_pwm_period;
    logic [CFG_W-1:0] r_link_timeout;
    logic [CFG_W-1:0] r_default_ivl;

    logic             r_in_opcode;
    logic [31:0]      r_in_now;
    logic [7:0]       r_in_lspeed, r_in_ldir, r_in_rspeed, r_in_rdir;
    logic [15:0]      r_in_lcnt, r_in_rcnt;

    logic [3:0]        r_pins;
    logic [15:0]       r_cmp_l, r_cmp_r;
    logic [31:0]       r_last_cmd, r_last_sample;
    logic [CB-1:0]     r_prev_l, r_prev_r;
    logic [31:0]       r_total_l, r_total_r;
    logic [RATE_W-1:0] r_rate_l, r_rate_r;
    logic [15:0]       r_fb_l, r_fb_r;

    logic              r_out_valid;
    logic [3:0]        r_out_pins;
    logic [15:0]       r_out_cmp_l, r_out_cmp_r, r_out_fb_l, r_out_fb_r;
    logic [RATE_W-1:0] r_out_rate_l, r_out_rate_r;

    logic              w_accept, w_prep, w_div_done, w_load;
    logic [31:0]       w_lcnt_ext, w_rcnt_ext;
    logic [CB-1:0]     w_cnt_l, w_cnt_r, w_d_l, w_d_r, w_mag_l, w_mag_r;
    logic [31:0]       w_cmd_age, w_dt_raw, w_dt;
    logic [23:0]       w_cmp_prod_l, w_cmp_prod_r;
    logic [NUM_W-1:0]  w_num_l, w_num_r;
    logic [DEN_W-1:0]  w_den;
    logic              w_timeout;
    t_div_stat         w_stat_l, w_stat_r;
    logic [NUM_W-1:0]  w_quot_l, w_quot_r;
    logic [RATE_W-1:0] w_rate_l, w_rate_r;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_prep      = (r_state == S_PREP);
    assign w_div_done  = (r_state == S_DIV) && w_stat_l.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_stat_l.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period   <= RST_PWM_PERIOD;
            r_link_timeout <= RST_LINK_TIMEOUT;
            r_default_ivl  <= RST_DEFAULT_IVL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data;
                CFG_LINK_TIMEOUT: r_link_timeout <= i_cfg_data;
                CFG_DEFAULT_IVL:  r_default_ivl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_opcode <= i_opcode;
            r_in_now    <= i_now_ms;
            r_in_lspeed <= i_left_speed_cmd;
            r_in_ldir   <= i_left_dir_cmd;
            r_in_rspeed <= i_right_speed_cmd;
            r_in_rdir   <= i_right_dir_cmd;
            r_in_lcnt   <= i_left_counter;
            r_in_rcnt   <= i_right_counter;
        end
    end

    // operand preparation
    always_comb begin
        w_lcnt_ext = {16'b0, r_in_lcnt};
        w_rcnt_ext = {16'b0, r_in_rcnt};
        w_cnt_l    = w_lcnt_ext[CB-1:0];
        w_cnt_r    = w_rcnt_ext[CB-1:0];
        w_d_l      = w_cnt_l - r_prev_l;
        w_d_r      = w_cnt_r - r_prev_r;
        w_mag_l    = w_d_l[CB-1] ? (~w_d_l + CB'(1)) : w_d_l;
        w_mag_r    = w_d_r[CB-1] ? (~w_d_r + CB'(1)) : w_d_r;

        w_cmd_age  = r_in_now - r_last_cmd;
        w_timeout  = (w_cmd_age > {16'b0, r_link_timeout});
        w_dt_raw   = r_in_now - r_last_sample;
        if (w_dt_raw != 32'd0) begin
            w_dt = w_dt_raw;
        end else if (r_default_ivl != '0) begin
            w_dt = {16'b0, r_default_ivl};
        end else begin
            w_dt = 32'd1;
        end

        w_cmp_prod_l = 24'(r_in_lspeed) * 24'(r_pwm_period);
        w_cmp_prod_r = 24'(r_in_rspeed) * 24'(r_pwm_period);

        if (r_in_opcode == OP_CMD) begin
            w_num_l = NUM_W'(w_cmp_prod_l);
            w_num_r = NUM_W'(w_cmp_prod_r);
            w_den   = CMP_DIVISOR;
        end else begin
            w_num_l = NUM_W'(w_mag_l) * NUM_W'(RATE_SCALE);
            w_num_r = NUM_W'(w_mag_r) * NUM_W'(RATE_SCALE);
            w_den   = DEN_W'(w_dt) + (DEN_W'(w_dt) << 3);
        end
    end

    dhdo_div #(
        .NUM_W (NUM_W)
    ) u_div_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_prep),
        .i_num   (w_num_l),
        .i_den   (w_den),
        .o_stat  (w_stat_l),
        .o_quot  (w_quot_l)
    );

    dhdo_div #(
        .NUM_W (NUM_W)
    ) u_div_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_prep),
        .i_num   (w_num_r),
        .i_den   (w_den),
        .o_stat  (w_stat_r),
        .o_quot  (w_quot_r)
    );

    assign w_rate_l = (|w_quot_l[NUM_W-1:RATE_W]) ? RATE_MAX : w_quot_l[RATE_W-1:0];
    assign w_rate_r = (|w_quot_r[NUM_W-1:RATE_W]) ? RATE_MAX : w_quot_r[RATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins        <= '0;
            r_cmp_l       <= '0;
            r_cmp_r       <= '0;
            r_last_cmd    <= '0;
            r_last_sample <= '0;
            r_prev_l      <= '0;
            r_prev_r      <= '0;
            r_total_l     <= '0;
            r_total_r     <= '0;
            r_rate_l      <= '0;
            r_rate_r      <= '0;
            r_fb_l        <= '0;
            r_fb_r        <= '0;
        end else if (w_prep) begin
            if (r_in_opcode == OP_CMD) begin
                r_last_cmd <= r_in_now;
                r_pins     <= {pins_for(r_in_rspeed, r_in_rdir),
                               pins_for(r_in_lspeed, r_in_ldir)};
                r_fb_l     <= r_total_l[15:0];
                r_fb_r     <= r_total_r[15:0];
            end else begin
                if (w_timeout) begin
                    r_pins  <= '0;
                    r_cmp_l <= '0;
                    r_cmp_r <= '0;
                end
                r_last_sample <= r_in_now;
                r_prev_l      <= w_cnt_l;
                r_prev_r      <= w_cnt_r;
                r_total_l     <= r_total_l + 32'(w_mag_l);
                r_total_r     <= r_total_r + 32'(w_mag_r);
            end
        end else if (w_div_done) begin
            if (r_in_opcode == OP_CMD) begin
                r_cmp_l <= w_quot_l[15:0];
                r_cmp_r <= w_quot_r[15:0];
            end else begin
                r_rate_l <= w_rate_l;
                r_rate_r <= w_rate_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pins   <= r_pins;
            r_out_cmp_l  <= r_cmp_l;
            r_out_cmp_r  <= r_cmp_r;
            r_out_rate_l <= r_rate_l;
            r_out_rate_r <= r_rate_r;
            r_out_fb_l   <= r_fb_l;
            r_out_fb_r   <= r_fb_r;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_pin_a     = r_out_pins[0];
    assign o_left_pin_b     = r_out_pins[1];
    assign o_right_pin_a    = r_out_pins[2];
    assign o_right_pin_b    = r_out_pins[3];
    assign o_left_compare   = r_out_cmp_l;
    assign o_right_compare  = r_out_cmp_r;
    assign o_left_rate      = r_out_rate_l;
    assign o_right_rate     = r_out_rate_r;
    assign o_left_feedback  = r_out_fb_l;
    assign o_right_feedback = r_out_fb_r;

    a_no_shoot_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pins[0] && r_pins[1]) && !(r_pins[2] && r_pins[3]))
        else $error("bridge pins a and b both high");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat_l.done == w_stat_r.done) && (w_stat_l.busy == w_stat_r.busy))
        else $error("dividers out of step");

    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_stat_l.busy && !w_stat_l.done)
        else $error("input ready while divider active");

    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown outside final state");

endmodule

`default_nettype wire

[bench/dual_hbridge_drive_with_odometry_unit_test.sv]
`timescale 1ns / 100ps

module dual_hbridge_drive_with_odometry_unit_test;

    import dhdo_pkg::*;

    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct packed {
        logic        op;
        logic [31:0] now;
        logic [7:0]  l_speed;
        logic [7:0]  l_dir;
        logic [7:0]  r_speed;
        logic [7:0]  r_dir;
        logic [15:0] l_count;
        logic [15:0] r_count;
    } t_drive_req;

    typedef struct packed {
        logic              la;
        logic              lb;
        logic              ra;
        logic              rb;
        logic [15:0]       l_cmp;
        logic [15:0]       r_cmp;
        logic [RATE_W-1:0] l_rate;
        logic [RATE_W-1:0] r_rate;
        logic [15:0]       l_fb;
        logic [15:0]       r_fb;
    } t_bridge_report;

    typedef struct packed {
        t_drive_req     req;
        logic           typed;
        t_bridge_report want;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_opcode = 1'b0;
    logic [31:0]       i_now_ms = '0;
    logic [7:0]        i_left_speed_cmd = '0;
    logic [7:0]        i_left_dir_cmd = '0;
    logic [7:0]        i_right_speed_cmd = '0;
    logic [7:0]        i_right_dir_cmd = '0;
    logic [15:0]       i_left_counter = '0;
    logic [15:0]       i_right_counter = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_left_pin_a;
    logic              o_left_pin_b;
    logic              o_right_pin_a;
    logic              o_right_pin_b;
    logic [15:0]       o_left_compare;
    logic [15:0]       o_right_compare;
    logic [RATE_W-1:0] o_left_rate;
    logic [RATE_W-1:0] o_right_rate;
    logic [15:0]       o_left_feedback;
    logic [15:0]       o_right_feedback;

    dual_hbridge_drive_with_odometry_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_now_ms          (i_now_ms),
        .i_left_speed_cmd  (i_left_speed_cmd),
        .i_left_dir_cmd    (i_left_dir_cmd),
        .i_right_speed_cmd (i_right_speed_cmd),
        .i_right_dir_cmd   (i_right_dir_cmd),
        .i_left_counter    (i_left_counter),
        .i_right_counter   (i_right_counter),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_left_pin_a      (o_left_pin_a),
        .o_left_pin_b      (o_left_pin_b),
        .o_right_pin_a     (o_right_pin_a),
        .o_right_pin_b     (o_right_pin_b),
        .o_left_compare    (o_left_compare),
        .o_right_compare   (o_right_compare),
        .o_left_rate       (o_left_rate),
        .o_right_rate      (o_right_rate),
        .o_left_feedback   (o_left_feedback),
        .o_right_feedback  (o_right_feedback)
    );

    always #2 i_clk = ~i_clk;

    // drive and odometry state as the block should hold it
    logic [CFG_W-1:0]  cfg_period;
    logic [CFG_W-1:0]  cfg_timeout;
    logic [CFG_W-1:0]  cfg_interval;
    logic [1:0]        bridge[2];
    logic [15:0]       compare[2];
    logic [31:0]       cmd_ms;
    logic [31:0]       sample_ms;
    logic [15:0]       prev_count[2];
    logic [31:0]       pulse_total[2];
    logic [RATE_W-1:0] rate[2];
    logic [15:0]       feedback[2];

    t_bridge_report pending_reports[$];
    t_plan_row      plan[$];

    int mismatches = 0;
    int reports_seen = 0;
    int items_sent = 0;
    int settings_used = 1;
    int burst_left = 0;
    int send_mode = 1;
    int recv_mode = 2;
    int beat = 0;
    logic [31:0] stall_bits = '1;

    logic [31:0] stamp_ms = '0;
    logic [15:0] enc[2] = '{16'd0, 16'd0};

    t_bridge_report seen;
    t_bridge_report wanted;
    string          why;

    function automatic logic [15:0] duty_compare(input logic [7:0] speed);
        logic [31:0] p;
        p = {24'b0, speed} * {16'b0, cfg_period};
        return 16'(p / 32'd255);
    endfunction

    function automatic logic [1:0] pick_pins(input logic [7:0] speed, input logic [7:0] dir);
        if (speed == 8'd0) begin
            return PINS_STOP;
        end
        return (dir == DIR_FWD) ? PINS_FWD : PINS_REV;
    endfunction

    task automatic next_drive_report(input t_drive_req r, output t_bridge_report rep);
        logic [31:0]       dt;
        logic [15:0]       cnt[2];
        logic [15:0]       d;
        logic [16:0]       mag;
        logic [63:0]       q;
        if (r.op == OP_CMD) begin
            cmd_ms = r.now;
            bridge[0] = pick_pins(r.l_speed, r.l_dir);
            bridge[1] = pick_pins(r.r_speed, r.r_dir);
            compare[0] = duty_compare(r.l_speed);
            compare[1] = duty_compare(r.r_speed);
            feedback[0] = pulse_total[0][15:0];
            feedback[1] = pulse_total[1][15:0];
        end else begin
            if (r.now - cmd_ms > {16'b0, cfg_timeout}) begin
                bridge[0] = PINS_STOP;
                bridge[1] = PINS_STOP;
                compare[0] = '0;
                compare[1] = '0;
            end
            dt = r.now - sample_ms;
            sample_ms = r.now;
            if (dt == 0) dt = {16'b0, cfg_interval};
            if (dt == 0) dt = 32'd1;
            cnt[0] = r.l_count;
            cnt[1] = r.r_count;
            for (int i = 0; i < 2; i++) begin
                d = cnt[i] - prev_count[i];
                mag = d[15] ? 17'h10000 - {1'b0, d} : {1'b0, d};
                prev_count[i] = cnt[i];
                pulse_total[i] = pulse_total[i] + {15'b0, mag};
                q = ({47'b0, mag} * 64'd550) / ({32'b0, dt} * 64'd9);
                rate[i] = (q > {43'b0, RATE_MAX}) ? RATE_MAX : q[RATE_W-1:0];
            end
        end
        rep.la = bridge[0][0];
        rep.lb = bridge[0][1];
        rep.ra = bridge[1][0];
        rep.rb = bridge[1][1];
        rep.l_cmp = compare[0];
        rep.r_cmp = compare[1];
        rep.l_rate = rate[0];
        rep.r_rate = rate[1];
        rep.l_fb = feedback[0];
        rep.r_fb = feedback[1];
    endtask

    function automatic t_plan_row row(input logic op, input logic [31:0] now,
                                      input logic [7:0] ls, input logic [7:0] ld,
                                      input logic [7:0] rs, input logic [7:0] rd,
                                      input logic [15:0] lc, input logic [15:0] rc,
                                      input logic typed = 1'b0,
                                      input t_bridge_report want = '0);
        t_plan_row p;
        p.req = '{op, now, ls, ld, rs, rd, lc, rc};
        p.typed = typed;
        p.want = want;
        return p;
    endfunction

    function automatic string diff_fields(input t_bridge_report w, input t_bridge_report g);
        string s;
        s = "";
        if (w.la !== g.la) s = {s, " left_pin_a"};
        if (w.lb !== g.lb) s = {s, " left_pin_b"};
        if (w.ra !== g.ra) s = {s, " right_pin_a"};
        if (w.rb !== g.rb) s = {s, " right_pin_b"};
        if (w.l_cmp !== g.l_cmp) s = {s, " left_compare"};
        if (w.r_cmp !== g.r_cmp) s = {s, " right_compare"};
        if (w.l_rate !== g.l_rate) s = {s, " left_rate"};
        if (w.r_rate !== g.r_rate) s = {s, " right_rate"};
        if (w.l_fb !== g.l_fb) s = {s, " left_feedback"};
        if (w.r_fb !== g.r_fb) s = {s, " right_feedback"};
        return s;
    endfunction

    task automatic note_mismatch(input string what, input t_bridge_report w,
                                 input t_bridge_report g);
        mismatches++;
        if (mismatches <= 10) begin
            $display("report %0d:%s", reports_seen, what);
            $display("  want pins %b%b%b%b cmp %0d %0d rate %0d %0d fb %0d %0d",
                     w.la, w.lb, w.ra, w.rb, w.l_cmp, w.r_cmp, w.l_rate, w.r_rate,
                     w.l_fb, w.r_fb);
            $display("  got  pins %b%b%b%b cmp %0d %0d rate %0d %0d fb %0d %0d",
                     g.la, g.lb, g.ra, g.rb, g.l_cmp, g.r_cmp, g.l_rate, g.r_rate,
                     g.l_fb, g.r_fb);
        end
    endtask

    task automatic send_req(input t_drive_req r, input logic typed,
                            input t_bridge_report fixed);
        t_bridge_report want;
        int gap;
        if (burst_left == 0) begin
            case (send_mode)
                0: begin
                    gap = 0;
                    burst_left = 1000000;
                end
                1: begin
                    gap = $urandom_range(0, 3);
                    burst_left = $urandom_range(1, 16);
                end
                default: begin
                    gap = $urandom_range(0, 40);
                    burst_left = $urandom_range(1, 4);
                end
            endcase
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_opcode = r.op;
        i_now_ms = r.now;
        i_left_speed_cmd = r.l_speed;
        i_left_dir_cmd = r.l_dir;
        i_right_speed_cmd = r.r_speed;
        i_right_dir_cmd = r.r_dir;
        i_left_counter = r.l_count;
        i_right_counter = r.r_count;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        next_drive_report(r, want);
        pending_reports.push_back(typed ? fixed : want);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PWM_PERIOD:   cfg_period = data;
            CFG_LINK_TIMEOUT: cfg_timeout = data;
            CFG_DEFAULT_IVL:  cfg_interval = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_speed();
        int k;
        k = $urandom_range(0, 99);
        if (k < 15) return 8'd0;
        if (k < 30) return 8'd255;
        return 8'($urandom_range(1, 254));
    endfunction

    function automatic logic [7:0] pick_dir();
        return ($urandom_range(0, 1) != 0) ? DIR_FWD : 8'($urandom);
    endfunction

    // mostly plausible time steps and encoder motion, with jumps and half-range deltas
    task automatic gen_req(output t_drive_req r);
        int k;
        k = $urandom_range(0, 99);
        if (k < 12) begin
        end else if (k < 75) begin
            stamp_ms = stamp_ms + 32'($urandom_range(1, 150));
        end else if (k < 95) begin
            stamp_ms = stamp_ms + 32'($urandom_range(150, 1500));
        end else begin
            stamp_ms = $urandom;
        end
        r.now = stamp_ms;
        r.op = ($urandom_range(0, 99) < 30) ? OP_CMD : OP_SAMPLE;
        if (r.op == OP_CMD) begin
            r.l_speed = pick_speed();
            r.l_dir = pick_dir();
            r.r_speed = pick_speed();
            r.r_dir = pick_dir();
            r.l_count = 16'($urandom);
            r.r_count = 16'($urandom);
        end else begin
            for (int i = 0; i < 2; i++) begin
                k = $urandom_range(0, 99);
                if (k < 70) begin
                    enc[i] = enc[i] + 16'($urandom_range(0, 400)) - 16'd200;
                end else if (k < 78) begin
                    enc[i] = enc[i] + 16'h8000;
                end else if (k < 86) begin
                    enc[i] = enc[i] + (($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8001);
                end else begin
                    enc[i] = 16'($urandom);
                end
            end
            r.l_count = enc[0];
            r.r_count = enc[1];
            r.l_speed = 8'($urandom);
            r.l_dir = 8'($urandom);
            r.r_speed = 8'($urandom);
            r.r_dir = 8'($urandom);
        end
    endtask

    always @(negedge i_clk) begin
        if (recv_mode == 0) begin
            i_out_ready = 1'b1;
        end else begin
            if (beat == 0) begin
                stall_bits = (recv_mode == 1) ? ($urandom | $urandom) : ($urandom & $urandom);
                stall_bits[0] = 1'b1;
                beat = $urandom_range(3, 32);
            end
            beat--;
            i_out_ready = stall_bits[beat];
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_left_pin_a, o_left_pin_b, o_right_pin_a, o_right_pin_b,
                     o_left_compare, o_right_compare, o_left_rate, o_right_rate,
                     o_left_feedback, o_right_feedback};
            reports_seen++;
            if (pending_reports.size() == 0) begin
                note_mismatch(" unexpected report", '0, seen);
            end else begin
                wanted = pending_reports.pop_front();
                why = diff_fields(wanted, seen);
                if (why != "") note_mismatch(why, wanted, seen);
            end
        end
    end

    initial begin
        t_drive_req     req;
        t_bridge_report none;
        logic [CFG_W-1:0] per;
        logic [CFG_W-1:0] tmo;
        logic [CFG_W-1:0] ivl;
        int directed;

        none = '0;
        cfg_period = RST_PWM_PERIOD;
        cfg_timeout = RST_LINK_TIMEOUT;
        cfg_interval = RST_DEFAULT_IVL;
        cmd_ms = '0;
        sample_ms = '0;
        for (int i = 0; i < 2; i++) begin
            bridge[i] = PINS_STOP;
            compare[i] = '0;
            prev_count[i] = '0;
            pulse_total[i] = '0;
            rate[i] = '0;
            feedback[i] = '0;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset register values throughout the directed rows
        plan.push_back(row(OP_SAMPLE, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                           1'b1, '0));
        plan.push_back(row(OP_CMD, 32'd10, 8'd255, DIR_FWD, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF,
                           1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 16'd499, 16'd499,
                                  21'd0, 21'd0, 16'd0, 16'd0}));
        plan.push_back(row(OP_CMD, 32'd20, 8'd0, DIR_FWD, 8'd0, 8'hFF, 16'h0000, 16'h0000,
                           1'b1, '0));
        plan.push_back(row(OP_CMD, 32'd30, 8'd1, 8'd2, 8'd128, DIR_FWD, 16'hFFFF, 16'h1234));
        plan.push_back(row(OP_SAMPLE, 32'd100, 8'hAA, 8'h55, 8'hFF, 8'h01, 16'd1000, 16'hFFFF));
        // zero interval, half-range delta on the left
        plan.push_back(row(OP_SAMPLE, 32'd100, 8'h00, 8'h00, 8'h00, 8'h00, 16'h83E8, 16'hFFFF));
        plan.push_back(row(OP_SAMPLE, 32'd101, 8'h00, 8'h00, 8'h00, 8'h00, 16'd999, 16'h7FFE));
        plan.push_back(row(OP_SAMPLE, 32'd102, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'h7FFE));
        plan.push_back(row(OP_CMD, 32'd1000, 8'd200, DIR_FWD, 8'd200, 8'd3, 16'h0000, 16'h0000));
        // link timeout boundary: equal keeps running, one more stops
        plan.push_back(row(OP_SAMPLE, 32'd1500, 8'h00, 8'h00, 8'h00, 8'h00, 16'd10, 16'h7FF0));
        plan.push_back(row(OP_SAMPLE, 32'd1501, 8'h00, 8'h00, 8'h00, 8'h00, 16'd10, 16'h7FF0));
        plan.push_back(row(OP_CMD, 32'hFFFF_FFF0, 8'd255, DIR_FWD, 8'd7, DIR_FWD,
                           16'h0000, 16'hFFFF));
        plan.push_back(row(OP_SAMPLE, 32'h0000_0010, 8'h00, 8'h00, 8'h00, 8'h00,
                           16'd20, 16'h7FE0));
        plan.push_back(row(OP_SAMPLE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                           16'hFFFF, 16'h0000));
        plan.push_back(row(OP_CMD, 32'hFFFF_FFFF, 8'd255, 8'hFF, 8'd255, DIR_FWD,
                           16'h0000, 16'h0000));
        plan.push_back(row(OP_SAMPLE, 32'h0000_01F4, 8'h00, 8'h00, 8'h00, 8'h00,
                           16'hFFFF, 16'h0000));
        plan.push_back(row(OP_CMD, 32'd0, 8'h80, 8'd0, 8'h7F, 8'hFE, 16'h5555, 16'hAAAA));
        plan.push_back(row(OP_SAMPLE, 32'h8000_0000, 8'h00, 8'h00, 8'h00, 8'h00,
                           16'h5555, 16'hAAAA));

        foreach (plan[i]) begin
            send_req(plan[i].req, plan[i].typed, plan[i].want);
        end
        directed = items_sent;
        drain();
        stamp_ms = 32'h8000_0000;
        enc[0] = 16'h5555;
        enc[1] = 16'hAAAA;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    per = 16'hFFFF;
                    tmo = 16'hFFFF;
                    ivl = 16'hFFFF;
                end
                1: begin
                    per = 16'd0;
                    tmo = 16'd0;
                    ivl = 16'd0;
                end
                2: begin
                    per = 16'd255;
                    tmo = 16'd1;
                    ivl = 16'd1;
                end
                4: begin
                    per = 16'd1;
                    tmo = 16'd1000;
                    ivl = 16'd7;
                end
                6: begin
                    per = 16'hFFFF;
                    tmo = 16'd0;
                    ivl = 16'd1;
                end
                7: begin
                    per = RST_PWM_PERIOD;
                    tmo = RST_LINK_TIMEOUT;
                    ivl = RST_DEFAULT_IVL;
                end
                default: begin
                    per = 16'($urandom);
                    tmo = 16'($urandom_range(0, 2000));
                    ivl = 16'($urandom);
                end
            endcase
            if (ph % 2 == 1) write_reg(CFG_SPARE, 16'($urandom));
            write_reg(CFG_PWM_PERIOD, per);
            write_reg(CFG_LINK_TIMEOUT, tmo);
            write_reg(CFG_DEFAULT_IVL, ivl);
            settings_used++;
            send_mode = ph % 3;
            recv_mode = (ph + 1) % 3;
            burst_left = 0;
            repeat (ITEMS_PER_PHASE) begin
                gen_req(req);
                send_req(req, 1'b0, none);
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        $display("%0d drive items (%0d directed) under %0d register settings",
                 items_sent, directed, settings_used);
        $display("%0d reports checked, %0d mismatches", reports_seen, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("dual_hbridge_drive_with_odometry_unit: match");
        end else begin
            $display("dual_hbridge_drive_with_odometry_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timed out with %0d reports outstanding", pending_reports.size());
        $display("dual_hbridge_drive_with_odometry_unit: mismatch");
        $finish;
    end

endmodule
